@@ rtl/mwf_pkg.sv @@
`timescale 1ns / 1ps

package mwf_pkg;

  // window side limit set by the 25-entry mask
  localparam int WIN_LIM   = 5;
  localparam int MASK_BITS = 8 * WIN_LIM * WIN_LIM;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 64;

  // default build limits of the top level
  localparam int DEF_MAX_RADIUS = 2;
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_MAX_ROWS   = 1024;

  localparam logic [CFG_AW-1:0] REG_COLS   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ROWS   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MODE   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RADIUS = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MASK0  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MASK1  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MASK2  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_MASK3  = 3'd7;

  localparam logic [1:0] MODE_BIN_DIL  = 2'd0;
  localparam logic [1:0] MODE_GRAY_DIL = 2'd1;
  localparam logic [1:0] MODE_BIN_ERO  = 2'd2;
  localparam logic [1:0] MODE_GRAY_ERO = 2'd3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       out_last;
  } out_t;

  typedef struct packed {
    logic               emit;
    logic               last;
    logic [1:0]         mode;
    logic [1:0]         radius;
    logic [WIN_LIM-1:0] rowv;
    logic [WIN_LIM-1:0] colv;
  } ctl_t;

  function automatic logic is_erosion(input logic [1:0] mode);
    return (mode == MODE_BIN_ERO) || (mode == MODE_GRAY_ERO);
  endfunction

  // one window entry's contribution; out-of-image entries give the neutral value
  function automatic logic [8:0] term(input logic [1:0] mode, input logic vld,
                                      input logic [7:0] pix, input logic [7:0] m);
    logic [8:0] t;
    t = 9'd0;
    case (mode)
      MODE_BIN_DIL:  t = (vld && pix == 8'd1 && m == 8'd1) ? 9'd1 : 9'd0;
      MODE_GRAY_DIL: t = vld ? ({1'b0, pix} + {1'b0, m}) : 9'd0;
      MODE_BIN_ERO:  t = (vld && pix == 8'd0 && m == 8'd1) ? 9'd0 : 9'd1;
      default: begin
        if (!vld) t = {1'b0, PIX_MAX};
        else if (pix < m) t = 9'd0;
        else t = {1'b0, pix - m};
      end
    endcase
    return t;
  endfunction

  function automatic logic [8:0] combine(input logic [1:0] mode, input logic [8:0] a,
                                         input logic [8:0] b);
    if (is_erosion(mode)) return (b < a) ? b : a;
    return (b > a) ? b : a;
  endfunction

  // mask entry under window row k, window column m (both counted back from newest)
  function automatic logic [7:0] mask_at(input logic [MASK_BITS-1:0] mask,
                                         input logic [1:0] radius, input int k, input int m);
    int side;
    int idx;
    side = 2 * int'(radius) + 1;
    if (k >= side || m >= side) return 8'd0;
    idx = (side - 1 - k) * side + (side - 1 - m);
    return mask[idx*8 +: 8];
  endfunction

endpackage

@@ rtl/mwf_line_buf.sv @@
`timescale 1ns / 1ps

module mwf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/mwf_cell.sv @@
`timescale 1ns / 1ps

module mwf_cell #(
  parameter int WIN      = 5,
  parameter int CELL_IDX = 0
) (
  input  logic                           clk,
  input  logic                           shift_en,
  input  logic                           calc_en,
  input  logic [WIN-1:0][7:0]            col_in,
  output logic [WIN-1:0][7:0]            col_out,
  input  mwf_pkg::ctl_t                  ctl,
  input  logic [mwf_pkg::MASK_BITS-1:0]  mask,
  output logic [8:0]                     part
);

  logic [WIN-1:0][7:0] col_r;
  logic [8:0]          part_r;
  logic [8:0]          part_nxt;

  always_ff @(posedge clk) begin
    if (shift_en) col_r <= col_in;
  end

  // column reduction over the window rows held in this cell
  always_comb begin
    part_nxt = mwf_pkg::term(ctl.mode, ctl.rowv[0] && ctl.colv[CELL_IDX], col_r[0],
                             mwf_pkg::mask_at(mask, ctl.radius, 0, CELL_IDX));
    for (int k = 1; k < WIN; k++) begin
      part_nxt = mwf_pkg::combine(ctl.mode, part_nxt,
                   mwf_pkg::term(ctl.mode, ctl.rowv[k] && ctl.colv[CELL_IDX], col_r[k],
                                 mwf_pkg::mask_at(mask, ctl.radius, k, CELL_IDX)));
    end
  end

  always_ff @(posedge clk) begin
    if (calc_en) part_r <= part_nxt;
  end

  assign col_out = col_r;
  assign part    = part_r;

endmodule

@@ rtl/morphology_window_filter.sv @@
`timescale 1ns / 1ps

// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | mwf_pkg::in_t  (cmd, pixel_value)
// out     | output    | out_valid/out_stall | mwf_pkg::out_t (out_pixel, out_last)
// cfg     | input     | cfg_wr_en           | cfg_addr, cfg_wr_data
//
// one request per clock sustained while the output is not stalled; the request that
// completes a window reaches out_valid through line read, window shift, column reduce, final reduce
// line memories give one read and one write a clock, which sets the rate
// reset is synchronous on rst_n; line memories and window cells are not cleared,
// out-of-image positions are masked instead
// a stalled output holds the whole pipeline and raises in_stall

module morphology_window_filter #(
  parameter int MAX_RADIUS = mwf_pkg::DEF_MAX_RADIUS,
  parameter int MAX_COLS   = mwf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = mwf_pkg::DEF_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mwf_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mwf_pkg::out_t                out_data,
  input  logic                         cfg_wr_en,
  input  logic [mwf_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [mwf_pkg::CFG_DW-1:0]   cfg_wr_data
);

  // the mask caps the usable radius at two
  localparam int RAD_EFF = (MAX_RADIUS < 2) ? MAX_RADIUS : 2;
  localparam int WIN     = 2 * RAD_EFF + 1;
  localparam int NLINE   = 2 * RAD_EFF;
  localparam int COLW    = $clog2(MAX_COLS);
  localparam int CNTC    = $clog2(MAX_COLS + 1);
  localparam int ROWW    = $clog2(MAX_ROWS + 1);
  localparam int QW      = ROWW + CNTC;
  localparam int CMPW    = 13;
  localparam int RST_COLS = (640 < MAX_COLS) ? 640 : MAX_COLS;
  localparam int RST_ROWS = (480 < MAX_ROWS) ? 480 : MAX_ROWS;

  // configuration registers
  logic [10:0] cols_r, rows_r;
  logic [1:0]  mode_r, rad_r;
  logic [63:0] mask0_r, mask1_r, mask2_r;
  logic [7:0]  mask3_r;
  logic [mwf_pkg::MASK_BITS-1:0] mask_all;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= 11'd640;
      rows_r  <= 11'd480;
      mode_r  <= mwf_pkg::MODE_BIN_DIL;
      rad_r   <= 2'd1;
      mask0_r <= '0;
      mask1_r <= '0;
      mask2_r <= '0;
      mask3_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        mwf_pkg::REG_COLS:   cols_r  <= cfg_wr_data[10:0];
        mwf_pkg::REG_ROWS:   rows_r  <= cfg_wr_data[10:0];
        mwf_pkg::REG_MODE:   mode_r  <= cfg_wr_data[1:0];
        mwf_pkg::REG_RADIUS: rad_r   <= cfg_wr_data[1:0];
        mwf_pkg::REG_MASK0:  mask0_r <= cfg_wr_data;
        mwf_pkg::REG_MASK1:  mask1_r <= cfg_wr_data;
        mwf_pkg::REG_MASK2:  mask2_r <= cfg_wr_data;
        mwf_pkg::REG_MASK3:  mask3_r <= cfg_wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign mask_all = {mask3_r, mask2_r, mask1_r, mask0_r};

  // geometry clamped into the supported range
  logic [CNTC-1:0] cols_clamp;
  logic [ROWW-1:0] rows_clamp;
  logic [1:0]      rad_clamp;

  always_comb begin
    if (cols_r == 11'd0) cols_clamp = CNTC'(1);
    else if ({2'b0, cols_r} > CMPW'(MAX_COLS)) cols_clamp = CNTC'(MAX_COLS);
    else cols_clamp = CNTC'(cols_r);
    if (rows_r == 11'd0) rows_clamp = ROWW'(1);
    else if ({2'b0, rows_r} > CMPW'(MAX_ROWS)) rows_clamp = ROWW'(MAX_ROWS);
    else rows_clamp = ROWW'(rows_r);
    rad_clamp = (rad_r > 2'(RAD_EFF)) ? 2'(RAD_EFF) : rad_r;
  end

  // pipeline advance: everything moves unless a held result is stalled
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // frame state, positions
  logic [CNTC-1:0] fcols_r;
  logic [ROWW-1:0] frows_r;
  logic [1:0]      fmode_r, frad_r;
  logic [COLW-1:0] in_col_r, out_col_r;
  logic [ROWW-1:0] in_row_r, out_row_r;

  logic            take, is_pix, restart, drop, latch, go;
  logic [COLW-1:0] ic, oc;
  logic [ROWW-1:0] ir, orow;
  logic [CNTC-1:0] gc;
  logic [ROWW-1:0] gr;
  logic [1:0]      gm, grad;
  logic [QW-1:0]   q, d;
  mwf_pkg::ctl_t   ctl_a;
  logic [ROWW:0]   trow;
  logic [CNTC:0]   tcol;
  logic [COLW-1:0] in_col_nxt, out_col_nxt;
  logic [ROWW-1:0] in_row_nxt, out_row_nxt;

  assign take = in_valid && !in_stall;

  always_comb begin
    is_pix  = (in_data.cmd == mwf_pkg::CMD_PIXEL);
    restart = is_pix && (in_row_r >= frows_r);
    drop    = !is_pix && ((in_row_r < frows_r) || (out_row_r >= frows_r));
    ic      = restart ? '0 : in_col_r;
    ir      = restart ? '0 : in_row_r;
    oc      = restart ? '0 : out_col_r;
    orow    = restart ? '0 : out_row_r;
    // frame settings are sampled on the first pixel of a frame
    latch   = is_pix && (ir == '0) && (ic == '0);
    gc      = latch ? cols_clamp : fcols_r;
    gr      = latch ? rows_clamp : frows_r;
    gm      = latch ? mode_r     : fmode_r;
    grad    = latch ? rad_clamp  : frad_r;
    go      = take && !drop;

    // raster index of this request against the window delay
    q = QW'(ir) * QW'(gc) + QW'(ic);
    d = QW'(grad) * QW'(gc) + QW'(grad);

    ctl_a.emit   = (q >= d) && (orow < gr);
    ctl_a.last   = ((ROWW+1)'(orow) + 1'b1 == (ROWW+1)'(gr)) &&
                   ((CNTC+1)'(oc) + 1'b1 == (CNTC+1)'(gc));
    ctl_a.mode   = gm;
    ctl_a.radius = grad;
    trow = (ROWW+1)'(orow) + (ROWW+1)'(grad);
    tcol = (CNTC+1)'(oc) + (CNTC+1)'(grad);
    // window row k, column m are k rows and m columns back from the newest pixel
    for (int k = 0; k < mwf_pkg::WIN_LIM; k++) begin
      ctl_a.rowv[k] = (k <= 2 * int'(grad)) && (trow >= (ROWW+1)'(k)) &&
                      (trow - (ROWW+1)'(k) < (ROWW+1)'(gr));
      ctl_a.colv[k] = (k <= 2 * int'(grad)) && (tcol >= (CNTC+1)'(k)) &&
                      (tcol - (CNTC+1)'(k) < (CNTC+1)'(gc));
    end

    if (CNTC'(ic) + 1'b1 >= gc) begin
      in_col_nxt = '0;
      in_row_nxt = ir + 1'b1;
    end else begin
      in_col_nxt = ic + 1'b1;
      in_row_nxt = ir;
    end
    out_col_nxt = oc;
    out_row_nxt = orow;
    if (ctl_a.emit) begin
      if (CNTC'(oc) + 1'b1 >= gc) begin
        out_col_nxt = '0;
        out_row_nxt = orow + 1'b1;
      end else begin
        out_col_nxt = oc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcols_r   <= CNTC'(RST_COLS);
      frows_r   <= ROWW'(RST_ROWS);
      fmode_r   <= mwf_pkg::MODE_BIN_DIL;
      frad_r    <= 2'd1;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (go) begin
      if (latch) begin
        fcols_r <= gc;
        frows_r <= gr;
        fmode_r <= gm;
        frad_r  <= grad;
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // stage b: line memory read data and the newest window column
  logic                   vld_b_r;
  logic [COLW-1:0]        col_b_r;
  logic [7:0]             pix_b_r;
  mwf_pkg::ctl_t          ctl_b_r;
  logic                   fwd_b_r;
  logic [NLINE-1:0][7:0]  fwd_data_r;
  logic [NLINE-1:0][7:0]  rd_data;
  logic [WIN-1:0][7:0]    colvec_b;
  logic                   wr_b;

  assign wr_b = vld_b_r && adv;

  always_comb begin
    colvec_b[0] = pix_b_r;
    for (int k = 0; k < NLINE; k++) begin
      // a write of the same column on the read edge is not yet in memory
      colvec_b[k+1] = fwd_b_r ? fwd_data_r[k] : rd_data[k];
    end
  end

  for (genvar k = 0; k < NLINE; k++) begin : g_line
    mwf_line_buf #(
      .DEPTH (MAX_COLS),
      .AW    (COLW)
    ) u_line (
      .clk     (clk),
      .rd_en   (go),
      .rd_addr (ic),
      .rd_data (rd_data[k]),
      .wr_en   (wr_b),
      .wr_addr (col_b_r),
      .wr_data (colvec_b[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_b_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      col_b_r    <= ic;
      pix_b_r    <= in_data.pixel_value;
      ctl_b_r    <= ctl_a;
      fwd_b_r    <= vld_b_r && (col_b_r == ic);
      fwd_data_r <= colvec_b[NLINE-1:0];
    end
  end

  // stage c: window held in the row of cells, stage d: per-column partials
  logic                 vld_c_r, vld_d_r;
  mwf_pkg::ctl_t        ctl_c_r, ctl_d_r;
  logic [WIN-1:0][WIN-1:0][7:0] cell_col;
  logic [WIN-1:0][8:0]  part;

  for (genvar m = 0; m < WIN; m++) begin : g_cell
    mwf_cell #(
      .WIN      (WIN),
      .CELL_IDX (m)
    ) u_cell (
      .clk      (clk),
      .shift_en (wr_b),
      .calc_en  (adv),
      .col_in   ((m == 0) ? colvec_b : cell_col[(m == 0) ? 0 : m-1]),
      .col_out  (cell_col[m]),
      .ctl      (ctl_c_r),
      .mask     (mask_all),
      .part     (part[m])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else if (adv) begin
      vld_c_r <= vld_b_r && ctl_b_r.emit;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
    end
  end

  // final reduction across cells, clipped to pixel range
  logic [8:0]     acc;
  mwf_pkg::out_t  out_nxt;
  mwf_pkg::out_t  out_data_r;

  always_comb begin
    acc = part[0];
    for (int m = 1; m < WIN; m++) begin
      acc = mwf_pkg::combine(ctl_d_r.mode, acc, part[m]);
    end
    out_nxt.out_pixel = acc[8] ? mwf_pkg::PIX_MAX : acc[7:0];
    out_nxt.out_last  = ctl_d_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_d_r) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/mwf_checker.sv @@
`timescale 1ns / 1ps

module mwf_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input mwf_pkg::out_t out_data
);

  // pipeline only backs up behind a held, stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output");

  // reset empties the output
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output dropped");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled output changed");

endmodule

bind morphology_window_filter mwf_checker u_mwf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
